>>> rtl/core/vmt_pkg.sv
// Package for the 4x4 vertex transform core: element, vector and lane result types,
// matrix register constants and the identity reset values.
// No dependencies; used by every module of the core.
package vmt_pkg;

    localparam int ElemW    = 32;
    localparam int NumComp  = 4;
    localparam int NumPairs = 8;
    localparam int PairW    = 2 * ElemW;
    localparam int CfgIdxW  = 4;
    localparam int FracW    = 16;
    localparam int ProdW    = 2 * ElemW;
    localparam int SumW     = ProdW + 2;

    typedef logic signed [ElemW-1:0] elem_t;
    typedef elem_t [NumComp-1:0] vec_t;
    typedef logic [PairW-1:0] pair_t;
    typedef logic [CfgIdxW-1:0] cfg_idx_t;

    typedef struct packed {
        elem_t value;
        logic  sat;
    } lane_res_t;

    localparam elem_t SatMax = 32'sh7FFF_FFFF;
    localparam elem_t SatMin = 32'sh8000_0000;

    localparam pair_t PairReset [NumPairs] = '{
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000
    };

endpackage

>>> rtl/core/vmt_lane.sv
// One output lane: four signed products, a two-level sum, shift and saturation.
// Depends on vmt_pkg; instantiated four times by vertex_matrix_transform_core.
module vmt_lane
(
    input  logic               clk,
    input  vmt_pkg::vec_t      vertex,
    input  vmt_pkg::vec_t      column,
    output vmt_pkg::lane_res_t res
);
    import vmt_pkg::*;

    logic signed [ProdW-1:0] prod_reg [NumComp];
    logic signed [ProdW:0]   pair_reg [2];
    logic signed [SumW-1:0]  sum;
    logic                    fits;
    lane_res_t               res_reg;
    lane_res_t               res_next;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NumComp; i++)
        begin
            prod_reg[i] <= ProdW'(vertex[i] * column[i]);
        end
        pair_reg[0] <= (ProdW+1)'(prod_reg[0]) + (ProdW+1)'(prod_reg[1]);
        pair_reg[1] <= (ProdW+1)'(prod_reg[2]) + (ProdW+1)'(prod_reg[3]);
        res_reg     <= res_next;
    end

    // The shifted sum fits in 32 bits when every bit above bit 46 matches the sign.
    always_comb
    begin
        sum  = SumW'(pair_reg[0]) + SumW'(pair_reg[1]);
        fits = (&sum[SumW-1:ElemW+FracW-1]) || !(|sum[SumW-1:ElemW+FracW-1]);
        res_next.sat = !fits;
        if (fits)
        begin
            res_next.value = sum[ElemW+FracW-1:FracW];
        end
        else if (sum[SumW-1])
        begin
            res_next.value = SatMin;
        end
        else
        begin
            res_next.value = SatMax;
        end
    end

    assign res = res_reg;

endmodule

>>> rtl/core/vmt_merge.sv
// Merging stage: gathers the four lane results, combines their saturation flags
// into one overflow bit and registers the result with its strobe. Depends on vmt_pkg.
module vmt_merge
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               valid,
    input  vmt_pkg::lane_res_t lane_res [vmt_pkg::NumComp],
    output vmt_pkg::vec_t      result,
    output logic               overflow,
    output logic               done
);
    import vmt_pkg::*;

    vec_t result_reg;
    logic overflow_reg;
    logic done_reg;
    logic overflow_next;

    always_comb
    begin
        overflow_next = 1'b0;
        for (int j = 0; j < NumComp; j++)
        begin
            overflow_next = overflow_next | lane_res[j].sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= valid;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < NumComp; j++)
        begin
            result_reg[j] <= lane_res[j].value;
        end
        overflow_reg <= overflow_next;
    end

    assign result   = result_reg;
    assign overflow = overflow_reg;
    assign done     = done_reg;

endmodule

>>> rtl/core/vertex_matrix_transform_core.sv
// Top level of the 4x4 vertex transform: matrix registers, input capture,
// four vmt_lane instances and the vmt_merge stage. Depends on vmt_pkg.
//
//   Channel   Handshake            Payload
//   input     start / busy         pos_x, pos_y, pos_z, pos_w
//   result    done (strobe)        out_x, out_y, out_z, out_w, overflow
//   config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One vertex is taken every cycle; busy is always low and cfg_ready always high.
// A result passes the input register, product, pair sum, final sum with saturation,
// and the merge register, and is on the outputs while done is high.
// Reset loads the identity matrix and clears the strobe pipeline.
// The receiver cannot stall, so nothing in the pipeline ever waits.
module vertex_matrix_transform_core
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  vmt_pkg::elem_t        pos_x,
    input  vmt_pkg::elem_t        pos_y,
    input  vmt_pkg::elem_t        pos_z,
    input  vmt_pkg::elem_t        pos_w,
    output logic                  done,
    output vmt_pkg::elem_t        out_x,
    output vmt_pkg::elem_t        out_y,
    output vmt_pkg::elem_t        out_z,
    output vmt_pkg::elem_t        out_w,
    output logic                  overflow,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  vmt_pkg::cfg_idx_t     cfg_index,
    input  vmt_pkg::pair_t        cfg_data
);
    import vmt_pkg::*;

    localparam int LaneLat = 3;

    pair_t              pair_reg [NumPairs];
    vec_t               vtx_reg;
    logic               in_vld_reg;
    logic [LaneLat-1:0] vld_pipe_reg;
    vec_t               columns [NumComp];
    lane_res_t          lane_res [NumComp];
    vec_t               result;
    logic               accept;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NumPairs; k++)
            begin
                pair_reg[k] <= PairReset[k];
            end
        end
        else if (cfg_valid && cfg_ready && (cfg_index < CfgIdxW'(NumPairs)))
        begin
            pair_reg[cfg_index[$clog2(NumPairs)-1:0]] <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg   <= 1'b0;
            vld_pipe_reg <= '0;
        end
        else
        begin
            in_vld_reg   <= accept;
            vld_pipe_reg <= {vld_pipe_reg[LaneLat-2:0], in_vld_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            vtx_reg <= {pos_w, pos_z, pos_y, pos_x};
        end
    end

    // Lane j uses column j of the matrix: element 4*i + j for input component i.
    for (genvar j = 0; j < NumComp; j++)
    begin : g_lane
        for (genvar i = 0; i < NumComp; i++)
        begin : g_elem
            localparam int Elem = NumComp * i + j;
            assign columns[j][i] = pair_reg[Elem / 2][(Elem % 2) * ElemW +: ElemW];
        end

        vmt_lane u_lane
        (
            .clk    (clk),
            .vertex (vtx_reg),
            .column (columns[j]),
            .res    (lane_res[j])
        );
    end

    vmt_merge u_merge
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid    (vld_pipe_reg[LaneLat-1]),
        .lane_res (lane_res),
        .result   (result),
        .overflow (overflow),
        .done     (done)
    );

    assign out_x = result[0];
    assign out_y = result[1];
    assign out_z = result[2];
    assign out_w = result[3];

endmodule
